/* hdl/mmdp_pkg.sv */
// Shared constants for the min/max difference pair finder.
// No dependencies; used by min_max_difference_pairs.
`default_nettype none

package mmdp_pkg;

  // tuser layout of the result stream, lowest bit first
  localparam int unsigned USER_KIND = 0;
  localparam int unsigned USER_FEW  = 1;
  localparam int unsigned USER_OVF  = 2;
  localparam int unsigned USER_W    = 3;

  // result kinds
  localparam logic KIND_MIN = 1'b0;
  localparam logic KIND_MAX = 1'b1;

endpackage

`default_nettype wire

/* hdl/min_max_difference_pairs.sv */
// Closest and farthest pairs of a small set of signed values.
// Depends on mmdp_pkg (tuser layout, kind codes).
//
// Loads one signed value per request into a store of MAX_ELEMENTS entries;
// the request with tlast ends the set. The block then makes three passes over the n*(n-1)/2
// pairs, all through one absolute-difference unit fed by a registered two-port read of the
// store: a search pass for the least and greatest difference, a pass emitting the pairs at the
// least difference (kind 0), and a pass emitting the pairs at the greatest (kind 1). Each pair
// is first read from the store and then evaluated; a matching pair waits while the output is
// stalled. Input is not ready during the search. Values beyond the store are dropped and
// flag every result of the set; a set of fewer than two values gives one result with too_few
// set.
`default_nettype none

module min_max_difference_pairs #(
  parameter int unsigned MAX_ELEMENTS  = 8,
  parameter int unsigned ELEMENT_WIDTH = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    s_axis_tvalid_i,
  output logic                                         s_axis_tready_o,
  // value
  input  wire logic [((ELEMENT_WIDTH+7)/8)*8-1:0]      s_axis_tdata_i,
  // is_last
  input  wire logic                                    s_axis_tlast_i,
  output logic                                         m_axis_tvalid_o,
  input  wire logic                                    m_axis_tready_i,
  // first_value, second_value, difference
  output logic [((3*ELEMENT_WIDTH+7)/8)*8-1:0]         m_axis_tdata_o,
  // kind, too_few, overflowed
  output logic [mmdp_pkg::USER_W-1:0]                  m_axis_tuser_o,
  // last_result
  output logic                                         m_axis_tlast_o
);

  localparam int unsigned EW     = ELEMENT_WIDTH;
  localparam int unsigned ODW    = ((3*ELEMENT_WIDTH+7)/8)*8;
  localparam int unsigned IW     = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW     = $clog2(MAX_ELEMENTS+1);
  localparam int unsigned NPAIRS = MAX_ELEMENTS*(MAX_ELEMENTS-1)/2;
  localparam int unsigned PW     = $clog2(NPAIRS+1);

  typedef enum logic [1:0] {S_LOAD, S_RD, S_EVAL, S_FEW} state_e;
  typedef enum logic [1:0] {P_SCAN, P_MIN, P_MAX} pass_e;

  state_e state_q, state_d;
  pass_e  pass_q, pass_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d;
  logic [EW-1:0] least_q, least_d, great_q, great_d;
  logic [PW-1:0] hi_cnt_q, hi_cnt_d;

  logic          o_valid_q, o_valid_d;
  logic          o_kind_q, o_kind_d, o_few_q, o_few_d, o_ovf_q, o_ovf_d, o_last_q, o_last_d;
  logic [EW-1:0] o_first_q, o_first_d, o_second_q, o_second_d, o_diff_q, o_diff_d;

  // element store, two registered read ports
  logic [EW-1:0] mem_q [MAX_ELEMENTS];
  logic [EW-1:0] rd_a_q, rd_b_q;

  logic          in_acc, wr_en, out_free, last_pair, last_in_row, match;
  logic [CW-1:0] cnt_new;
  logic signed [EW:0] a_x, b_x, sub_ab;
  logic [EW-1:0] diff;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_en    = in_acc && (cnt_q < CW'(MAX_ELEMENTS));
  assign out_free = !o_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cnt_q[IW-1:0]] <= s_axis_tdata_i[EW-1:0];
    end
    if (state_q == S_RD) begin
      rd_a_q <= mem_q[i_q];
      rd_b_q <= mem_q[j_q];
    end
  end

  // shared absolute-difference unit
  always_comb begin
    a_x    = {rd_a_q[EW-1], rd_a_q};
    b_x    = {rd_b_q[EW-1], rd_b_q};
    sub_ab = (a_x > b_x) ? (a_x - b_x) : (b_x - a_x);
    diff   = sub_ab[EW-1:0];
  end

  assign last_in_row = (cnt_q == CW'(j_q) + CW'(1));
  assign last_pair   = last_in_row && (cnt_q == CW'(i_q) + CW'(2));

  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    i_d        = i_q;
    j_d        = j_q;
    least_d    = least_q;
    great_d    = great_q;
    hi_cnt_d   = hi_cnt_q;
    o_valid_d  = o_valid_q && !m_axis_tready_i;
    o_kind_d   = o_kind_q;
    o_few_d    = o_few_q;
    o_ovf_d    = o_ovf_q;
    o_last_d   = o_last_q;
    o_first_d  = o_first_q;
    o_second_d = o_second_q;
    o_diff_d   = o_diff_q;
    cnt_new    = cnt_q;
    match      = 1'b0;

    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (wr_en) begin
            cnt_new = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          cnt_d = cnt_new;
          if (s_axis_tlast_i) begin
            if (cnt_new < CW'(2)) begin
              state_d = S_FEW;
            end else begin
              state_d  = S_RD;
              pass_d   = P_SCAN;
              i_d      = '0;
              j_d      = IW'(1);
              least_d  = '1;
              great_d  = '0;
              hi_cnt_d = '0;
            end
          end
        end
      end
      S_RD: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        case (pass_q)
          P_SCAN: begin
            if (diff < least_q) begin
              least_d = diff;
            end
            if (diff > great_q) begin
              great_d  = diff;
              hi_cnt_d = PW'(1);
            end else if (diff == great_q) begin
              hi_cnt_d = hi_cnt_q + PW'(1);
            end
          end
          P_MIN:   match = (diff == least_q);
          P_MAX:   match = (diff == great_q);
          default: match = 1'b0;
        endcase
        if (!match || out_free) begin
          if (match) begin
            o_valid_d  = 1'b1;
            o_kind_d   = (pass_q == P_MAX) ? mmdp_pkg::KIND_MAX : mmdp_pkg::KIND_MIN;
            o_few_d    = 1'b0;
            o_ovf_d    = ovf_q;
            o_first_d  = rd_a_q;
            o_second_d = rd_b_q;
            o_diff_d   = diff;
            // the count of greatest-difference pairs tells which result closes the set
            o_last_d   = (pass_q == P_MAX) && (hi_cnt_q == PW'(1));
            if (pass_q == P_MAX) begin
              hi_cnt_d = hi_cnt_q - PW'(1);
            end
          end
          state_d = S_RD;
          if (last_pair) begin
            i_d = '0;
            j_d = IW'(1);
            case (pass_q)
              P_SCAN: pass_d = P_MIN;
              P_MIN:  pass_d = P_MAX;
              default: begin
                state_d = S_LOAD;
                cnt_d   = '0;
                ovf_d   = 1'b0;
              end
            endcase
          end else if (last_in_row) begin
            i_d = i_q + IW'(1);
            j_d = i_q + IW'(2);
          end else begin
            j_d = j_q + IW'(1);
          end
        end
      end
      S_FEW: begin
        if (out_free) begin
          o_valid_d  = 1'b1;
          o_kind_d   = mmdp_pkg::KIND_MIN;
          o_few_d    = 1'b1;
          o_ovf_d    = ovf_q;
          o_last_d   = 1'b1;
          o_first_d  = '0;
          o_second_d = '0;
          o_diff_d   = '0;
          state_d    = S_LOAD;
          cnt_d      = '0;
          ovf_d      = 1'b0;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      pass_q    <= P_SCAN;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      hi_cnt_q  <= '0;
      o_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pass_q    <= pass_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      i_q       <= i_d;
      j_q       <= j_d;
      hi_cnt_q  <= hi_cnt_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    least_q    <= least_d;
    great_q    <= great_d;
    o_kind_q   <= o_kind_d;
    o_few_q    <= o_few_d;
    o_ovf_q    <= o_ovf_d;
    o_last_q   <= o_last_d;
    o_first_q  <= o_first_d;
    o_second_q <= o_second_d;
    o_diff_q   <= o_diff_d;
  end

  assign s_axis_tready_o = (state_q == S_LOAD);
  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tdata_o  = ODW'({o_diff_q, o_second_q, o_first_q});
  assign m_axis_tlast_o  = o_last_q;

  always_comb begin
    m_axis_tuser_o                       = '0;
    m_axis_tuser_o[mmdp_pkg::USER_KIND]  = o_kind_q;
    m_axis_tuser_o[mmdp_pkg::USER_FEW]   = o_few_q;
    m_axis_tuser_o[mmdp_pkg::USER_OVF]   = o_ovf_q;
  end

  // a too-few result is always the only, and so the final, one
  a_few_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q && o_few_q |-> o_last_q)
    else $error("too_few result not marked last");

  // a set of pairs always closes on a greatest-difference pair
  a_last_is_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q && o_last_q && !o_few_q |-> o_kind_q == mmdp_pkg::KIND_MAX)
    else $error("final pair result is not of the greatest kind");

  // a least-difference result always carries the least found in the search
  a_min_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q && !o_few_q && o_kind_q == mmdp_pkg::KIND_MIN |-> o_diff_q == least_q)
    else $error("least-difference result does not match the search");

  // each greatest-difference pair met in the emit pass still has a count left
  a_hi_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL && pass_q == P_MAX && diff == great_q |-> hi_cnt_q != '0)
    else $error("greatest-difference pair count exhausted early");

endmodule

`default_nettype wire

/* tb/min_max_difference_pairs_test.sv */
// Self-checking testbench for min_max_difference_pairs: loads sets of signed values,
// predicts the closest and farthest pairs of each set and checks every result in order.
// Depends on mmdp_pkg and the min_max_difference_pairs RTL only.
`default_nettype none

module min_max_difference_pairs_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_ELEMENTS  = 8;
  localparam int unsigned EW            = 16;
  localparam int unsigned IN_W          = ((EW + 7) / 8) * 8;
  localparam int unsigned OUT_W         = ((3 * EW + 7) / 8) * 8;
  localparam int          RANDOM_ITEMS  = 330;
  localparam int          LONG_HOLD     = 500;
  localparam int          SETTLE_CYCLES = 250;
  localparam int          CYCLE_LIMIT   = 1000000;

  localparam logic signed [EW-1:0] VALUE_MIN = {1'b1, {(EW-1){1'b0}}};
  localparam logic signed [EW-1:0] VALUE_MAX = {1'b0, {(EW-1){1'b1}}};

  typedef enum int {
    STYLE_FULL,
    STYLE_NARROW,
    STYLE_EXTREME,
    STYLE_COARSE,
    STYLE_REPEAT
  } value_style_e;

  typedef struct packed {
    logic                 kind;
    logic signed [EW-1:0] first_value;
    logic signed [EW-1:0] second_value;
    logic [EW-1:0]        difference;
    logic                 too_few;
    logic                 overflowed;
    logic                 last_result;
  } pair_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [mmdp_pkg::USER_W-1:0] m_axis_tuser;
  logic             m_axis_tlast;

  // predictor state: the set being loaded
  logic signed [EW-1:0] set_vals [MAX_ELEMENTS];
  int unsigned          set_len = 0;
  bit                   set_dropped = 1'b0;
  pair_result_t         pending_pairs[$];

  bit sender_eager = 1'b0;
  int hold_requests = 0;
  int holds_served = 0;
  int cycle_count = 0;
  int values_sent = 0;
  int sets_done = 0;
  int mismatches = 0;
  int min_pairs_seen = 0;
  int max_pairs_seen = 0;
  int too_few_seen = 0;
  int dropped_seen = 0;

  min_max_difference_pairs #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .ELEMENT_WIDTH(EW)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tlast_i (s_axis_tlast),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser),
    .m_axis_tlast_o (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_pairs.size());
      $display("min_max_difference_pairs test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic [EW-1:0] abs_gap(input logic signed [EW-1:0] a,
                                            input logic signed [EW-1:0] b);
    int da, db;
    logic [EW-1:0] gap;
    da = int'(a);
    db = int'(b);
    gap = EW'((da > db) ? da - db : db - da);
    return gap;
  endfunction

  function automatic void load_value(input logic signed [EW-1:0] v, input bit last);
    logic [EW-1:0] least, greatest, d, target;
    int lo, hi, total, emitted;
    pair_result_t r;
    if (set_len < MAX_ELEMENTS) begin
      set_vals[set_len] = v;
      set_len++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!last) return;
    sets_done++;
    r = '0;
    r.overflowed = set_dropped;
    if (set_len < 2) begin
      r.kind = mmdp_pkg::KIND_MIN;
      r.too_few = 1'b1;
      r.last_result = 1'b1;
      pending_pairs.push_back(r);
    end else begin
      least = abs_gap(set_vals[0], set_vals[1]);
      lo = int'(set_vals[0]);
      hi = lo;
      for (int i = 0; i < set_len; i++) begin
        if (set_vals[i] > hi) hi = int'(set_vals[i]);
        if (set_vals[i] < lo) lo = int'(set_vals[i]);
        for (int j = i + 1; j < set_len; j++) begin
          d = abs_gap(set_vals[i], set_vals[j]);
          if (d < least) least = d;
        end
      end
      greatest = EW'(hi - lo);
      // count first so the closing result can be marked as it is queued
      total = 0;
      for (int i = 0; i < set_len; i++)
        for (int j = i + 1; j < set_len; j++) begin
          d = abs_gap(set_vals[i], set_vals[j]);
          if (d == least) total++;
          if (d == greatest) total++;
        end
      emitted = 0;
      for (int k = 0; k < 2; k++) begin
        target = (k == 0) ? least : greatest;
        for (int i = 0; i < set_len; i++)
          for (int j = i + 1; j < set_len; j++) begin
            d = abs_gap(set_vals[i], set_vals[j]);
            if (d == target) begin
              emitted++;
              r.kind = (k == 0) ? mmdp_pkg::KIND_MIN : mmdp_pkg::KIND_MAX;
              r.first_value = set_vals[i];
              r.second_value = set_vals[j];
              r.difference = d;
              r.last_result = (emitted == total);
              pending_pairs.push_back(r);
            end
          end
      end
    end
    set_len = 0;
    set_dropped = 1'b0;
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin : check_results
    pair_result_t got, want;
    bit bad;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind         = m_axis_tuser[mmdp_pkg::USER_KIND];
      got.too_few      = m_axis_tuser[mmdp_pkg::USER_FEW];
      got.overflowed   = m_axis_tuser[mmdp_pkg::USER_OVF];
      got.first_value  = m_axis_tdata[EW-1:0];
      got.second_value = m_axis_tdata[2*EW-1:EW];
      got.difference   = m_axis_tdata[3*EW-1:2*EW];
      got.last_result  = m_axis_tlast;
      if (got.too_few) too_few_seen++;
      else if (got.kind == mmdp_pkg::KIND_MIN) min_pairs_seen++;
      else max_pairs_seen++;
      if (got.overflowed) dropped_seen++;
      if (pending_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result: kind %0d %0d,%0d diff %0d few %0d ovf %0d last %0d",
                   $realtime, got.kind, $signed(got.first_value), $signed(got.second_value),
                   got.difference, got.too_few, got.overflowed, got.last_result);
      end else begin
        want = pending_pairs.pop_front();
        bad = (got.kind !== want.kind) || (got.first_value !== want.first_value) ||
              (got.second_value !== want.second_value) ||
              (got.difference !== want.difference) || (got.too_few !== want.too_few) ||
              (got.overflowed !== want.overflowed) || (got.last_result !== want.last_result);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected kind %0d %0d,%0d diff %0d few %0d ovf %0d last %0d",
                     want.kind, $signed(want.first_value), $signed(want.second_value),
                     want.difference, want.too_few, want.overflowed, want.last_result);
            $display("  actual   kind %0d %0d,%0d diff %0d few %0d ovf %0d last %0d",
                     got.kind, $signed(got.first_value), $signed(got.second_value),
                     got.difference, got.too_few, got.overflowed, got.last_result);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  initial begin : result_sink
    int r, run;
    bit level;
    forever begin
      @(posedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served++;
        m_axis_tready <= 1'b0;
        for (int c = 0; c < LONG_HOLD; c++) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          level = 1'b1;
          run = $urandom_range(1, 40);
        end else if (r < 95) begin
          level = 1'b0;
          run = $urandom_range(1, 4);
        end else begin
          level = 1'b0;
          run = $urandom_range(10, 60);
        end
        m_axis_tready <= level;
        repeat (run - 1) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------- sender

  function automatic int pick_gap();
    int r;
    if (sender_eager) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [EW-1:0] pick_value(input value_style_e style);
    logic signed [EW-1:0] v;
    case (style)
      STYLE_NARROW: v = EW'($urandom_range(0, 6) - 3);
      STYLE_COARSE: v = EW'(($urandom_range(0, 64) - 32) * 1000);
      STYLE_EXTREME: begin
        case ($urandom_range(0, 4))
          0: v = VALUE_MIN;
          1: v = VALUE_MAX;
          2: v = '0;
          3: v = '1;
          default: v = EW'($urandom_range(0, 65535));
        endcase
      end
      default: v = EW'($urandom_range(0, 65535));
    endcase
    return v;
  endfunction

  task automatic send_value(input logic signed [EW-1:0] v, input bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'($unsigned(v));
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    load_value(v, last);
    values_sent++;
  endtask

  task automatic send_set(input int n, input value_style_e style);
    logic signed [EW-1:0] same;
    same = EW'($urandom_range(0, 65535));
    for (int i = 0; i < n; i++)
      send_value((style == STYLE_REPEAT) ? same : pick_value(style), i == n - 1);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_pairs.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_extreme_values();
    send_value(VALUE_MIN, 1'b0);
    send_value(VALUE_MAX, 1'b1);
    send_value(VALUE_MAX, 1'b0);
    send_value(VALUE_MIN, 1'b0);
    send_value('0, 1'b1);
    drain_results();
  endtask

  task automatic test_single_value();
    send_value(VALUE_MAX, 1'b1);
    send_value('1, 1'b1);
    drain_results();
  endtask

  // every pair is both closest and farthest: the longest burst of results
  task automatic test_equal_values();
    for (int i = 0; i < MAX_ELEMENTS; i++)
      send_value(VALUE_MIN, i == MAX_ELEMENTS - 1);
    drain_results();
  endtask

  // two requests beyond the store, the closing one dropped too
  task automatic test_store_overflow();
    logic signed [EW-1:0] vals [10];
    vals = '{VALUE_MAX, 16'sd100, -16'sd100, 16'sd7, 16'sd0, -16'sd1, 16'sd3, VALUE_MIN,
             16'sd55, 16'sd9};
    for (int i = 0; i < 10; i++) send_value(vals[i], i == 9);
    drain_results();
  endtask

  task automatic test_random_sets();
    int r, n;
    while (values_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) n = 1;
      else if (r < 18) n = $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 3);
      else if (r < 30) n = MAX_ELEMENTS;
      else n = $urandom_range(2, MAX_ELEMENTS - 1);
      sender_eager = ($urandom_range(0, 99) < 20);
      send_set(n, value_style_e'($urandom_range(0, 4)));
    end
    sender_eager = 1'b0;
    drain_results();
  endtask

  // receiver holds off while full sets keep arriving, so the input stalls
  task automatic test_output_hold();
    hold_requests++;
    sender_eager = 1'b1;
    send_set(MAX_ELEMENTS, STYLE_REPEAT);
    send_set(MAX_ELEMENTS, STYLE_NARROW);
    send_set(MAX_ELEMENTS, STYLE_FULL);
    sender_eager = 1'b0;
    drain_results();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extreme_values();
    test_single_value();
    test_equal_values();
    test_store_overflow();
    test_output_hold();
    test_random_sets();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_pairs.size() != 0) mismatches += pending_pairs.size();
    $display("Ran %0d values in %0d sets: %0d closest and %0d farthest pairs checked,",
             values_sent, sets_done, min_pairs_seen, max_pairs_seen);
    $display("%0d short-set results, %0d results flagged for dropped values, %0d mismatches.",
             too_few_seen, dropped_seen, mismatches);
    if (mismatches == 0) begin
      $display("min_max_difference_pairs test passed");
    end else begin
      $display("min_max_difference_pairs test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hdl/mmdp_pkg.sv
hdl/min_max_difference_pairs.sv
tb/min_max_difference_pairs_test.sv
